// ===== rtl/core/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and constants of the sorted array priority queue
// Holds the store size, field widths, operation and status codes, and the
// word that one storage cell carries.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int CAPACITY = 64;
   localparam int TAG_BITS = 16;
   localparam int PRIO_BITS = 32;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PEEK = 2'd2,
      OP_CLR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic signed [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]         tag;
   } entry_type;

   // Command broadcast to every cell in a cycle.
   typedef struct packed {
      logic ins;  // insert a new entry in order
      logic pop;  // drop the front entry, shift toward the front
   } cell_cmd_type;

endpackage

// ===== rtl/core/sapq_cell.sv =====
// ----------------------------------------------------------------------------
// sapq_cell: one storage cell of the sorted chain
// Holds one entry; on insert it keeps its entry, takes the new one or takes
// its front-side neighbor's, and on pop it takes its back-side neighbor's.
// ----------------------------------------------------------------------------
module sapq_cell
   import sapq_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         prev_keep,
   input  entry_type    new_entry,
   input  entry_type    front_entry,
   input  entry_type    back_entry,
   output entry_type    entry,
   output logic         keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // Entries strictly more urgent than the new one stay where they are, so
   // a new entry lands in front of any equal priorities.
   assign keep = occupied && (entry_ff.prio < new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = front_entry;
         end
      end else if (cmd.pop) begin
         entry_in = back_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue: min-priority queue in a sorted chain of cells
// Enqueue, dequeue, peek and clear on tagged signed Q16.16 priorities, with
// one result word for every request word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Fields
//   request   start, busy        req_op, req_priority_req, req_tag
//   response  rsp_strobe         rsp_status, rsp_front_priority, rsp_front_tag,
//                                rsp_count, rsp_is_empty
//
// A request word is taken at every clock edge where start is high; busy is
// never raised, so one word can be taken in every cycle.
// Its response word appears on the cycle after acceptance, for one cycle.
// Every operation is carried out by all cells of the chain acting in
// parallel, each looking only at its own entry and its two neighbors.
// Reset clears only the fill count and the response strobe; cell contents
// past the fill count are never looked at. The receiver cannot stall.
//
// The cells hold entries sorted with the most urgent at cell 0, which is
// therefore the front. Cells below the fill count are occupied. On an
// enqueue every occupied cell compares its priority to the new one; the
// cells that are strictly more urgent form a prefix and keep their entries,
// the first cell past that prefix takes the new entry and every cell behind
// it takes its front neighbor's entry, which opens a gap for the new
// entry. A dequeue moves every entry one cell toward the front.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
   import sapq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic signed [31:0]    req_priority_req,
   input  logic [15:0]           req_tag,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_front_priority,
   output logic [15:0]           rsp_front_tag,
   output logic [6:0]            rsp_count,
   output logic                  rsp_is_empty
);

   logic                accept;
   op_type              op;
   entry_type           new_entry;
   cell_cmd_type        cmd;
   logic                full;
   logic                empty;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   logic                strobe_ff;
   status_type          status_ff;
   status_type          status_in;
   logic signed [31:0]  front_prio_ff;
   logic signed [31:0]  front_prio_in;
   logic [15:0]         front_tag_ff;
   logic [15:0]         front_tag_in;
   logic [6:0]          rsp_count_ff;
   logic                is_empty_ff;

   entry_type           cell_entry [CAPACITY];
   logic                cell_keep  [CAPACITY];

   // The queue finishes every operation in the cycle it is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_op);

   assign new_entry.prio = req_priority_req;
   assign new_entry.tag  = req_tag[TAG_BITS-1:0];

   assign full  = (count_ff == CNT_BITS'(CAPACITY));
   assign empty = (count_ff == '0);

   assign cmd.ins = accept && (op == OP_ENQ) && !full;
   assign cmd.pop = accept && (op == OP_DEQ) && !empty;

   // The chain of cells. Cell 0 has no front neighbor, so it always sees
   // the "previous cell kept" condition; the last cell refills with its own
   // entry on a pop, which falls past the fill count anyway.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      prev_keep;
      entry_type front_entry;
      entry_type back_entry;

      assign occupied = (CNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_keep   = 1'b1;
         assign front_entry = new_entry;
      end else begin : g_mid
         assign prev_keep   = cell_keep[i-1];
         assign front_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign back_entry = cell_entry[i];
      end else begin : g_inner
         assign back_entry = cell_entry[i+1];
      end

      sapq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .prev_keep   (prev_keep),
         .new_entry   (new_entry),
         .front_entry (front_entry),
         .back_entry  (back_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   // Fill count and response word. The front entry is read before the
   // operation takes effect, so a dequeue returns what it removes.
   always_comb begin
      count_in      = count_ff;
      status_in     = ST_OK;
      front_prio_in = '0;
      front_tag_in  = '0;
      case (op)
         OP_ENQ: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_prio_in = cell_entry[0].prio;
               front_tag_in  = 16'(cell_entry[0].tag);
               if (op == OP_DEQ) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
         end
         OP_CLR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         front_prio_ff <= front_prio_in;
         front_tag_ff  <= front_tag_in;
         rsp_count_ff  <= 7'(count_in);
         is_empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_front_priority = front_prio_ff;
   assign rsp_front_tag      = front_tag_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_is_empty       = is_empty_ff;

`ifndef ASSERT_OFF
   // The fill count never passes the size of the chain.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count above capacity");

   // A dropped enqueue is reported only when every cell is occupied.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_FULL) |-> rsp_count == 7'(CAPACITY))
      else $error("full status with free cells");

   // The reported count agrees with the internal fill count.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_count == 7'(count_ff))
      else $error("reported count differs from fill count");

   // An empty status comes only with a count of zero and the empty flag set.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_EMPTY) |-> rsp_count == '0 && rsp_is_empty)
      else $error("empty status on a filled store");
`endif

endmodule
